### src/sed_pkg.sv
// shared types and constants for the saturating euclidean distance block
// used by sed_front, sed_root_cell and saturating_euclidean_distance; no dependencies
package sed_pkg;

    localparam int COORD_W    = 16;
    localparam int MAG_W      = 16;
    localparam int SQ_W       = 32;
    localparam int SUM_W      = 34;
    localparam int ROOT_W     = 31;
    localparam int SPAN_W     = 15;
    localparam int ROOT_STEPS = 15;

    // largest sum whose rounded root still fits: 32767^2 + 32767
    localparam logic [SUM_W-1:0]  SAT_LIMIT = SUM_W'(64'd1073709056);
    localparam logic [SPAN_W-1:0] SPAN_MAX  = {SPAN_W{1'b1}};

    typedef logic [MAG_W-1:0] t_mag;

    // one item moving down the root chain
    typedef struct packed {
        logic              valid;
        logic              sat;
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } t_root_lane;

endpackage

### src/saturating_euclidean_distance.sv
// saturating euclidean distance, top level: input register stages, root cell chain,
// rounding and an output register with skid. depends on sed_pkg, sed_front, sed_root_cell
//
// usage
//   slave channel: i_s_tvalid / o_s_tready, i_s_tdata carries both points, i_s_tuser
//   carries kind (0 planar, z ignored; 1 spatial). master channel: o_m_tvalid /
//   i_m_tready, o_m_tdata carries the rounded distance, saturated at 32767.
//   one item is accepted per cycle while the skid register is empty; every item
//   gives exactly one result, in order.
//   from acceptance to o_m_tvalid an item passes the registers for difference,
//   square, sum and the saturation check, then the root cells (15 cells, one
//   root bit each) and the output register.
//   throughput is one item per cycle while the skid register is empty, which is
//   when the root chain advances; a stall costs nothing while the receiver takes items.
//   when the receiver stalls, the output register holds its item, the next one
//   lands in the skid register, and o_s_tready drops the cycle after; the whole
//   chain then freezes in place until the skid register drains.
//   synchronous active-low reset empties the pipeline and both output registers;
//   there is no other state.
module saturating_euclidean_distance
    import sed_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z from bit 0 up
    input  logic [95:0] i_s_tdata,
    // kind
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // span in bits 14:0, bit 15 zero
    output logic [15:0] o_m_tdata
);

    logic              w_en;
    t_root_lane        w_lane [ROOT_STEPS+1];
    t_root_lane        w_last;
    logic [SPAN_W-1:0] w_span;

    logic              r_out_valid;
    logic [SPAN_W-1:0] r_out_span;
    logic              r_skid_valid;
    logic [SPAN_W-1:0] r_skid_span;

    assign w_en       = !r_skid_valid;
    assign o_s_tready = w_en;

    sed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_s_tvalid),
        .i_kind   (i_s_tuser),
        .i_coords (i_s_tdata),
        .o_lane   (w_lane[0])
    );

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_cell
        sed_root_cell #(
            .LEVEL (ROOT_STEPS - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_lane  (w_lane[k]),
            .o_lane  (w_lane[k+1])
        );
    end

    assign w_last = w_lane[ROOT_STEPS];

    // saturate, or round to nearest: bump when the remainder exceeds the floor root
    always_comb begin
        if (w_last.sat) begin
            w_span = SPAN_MAX;
        end else if (w_last.rem > w_last.root) begin
            w_span = SPAN_W'(w_last.root) + SPAN_W'(1);
        end else begin
            w_span = SPAN_W'(w_last.root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (r_out_valid && !i_m_tready) begin
            r_skid_valid <= w_last.valid;
        end else begin
            r_out_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_m_tready) begin
                r_out_span <= r_skid_span;
            end
        end else if (r_out_valid && !i_m_tready) begin
            r_skid_span <= w_span;
        end else begin
            r_out_span <= w_span;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_span};

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds an item while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_m_tready && w_last.valid))
        else $error("skid register filled without a stalled output");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_m_tready |=> !r_skid_valid && r_out_valid)
        else $error("skid register did not drain into the output register");

    a_chain_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |=> $stable(w_last))
        else $error("root chain moved while the skid register was full");
`endif

endmodule

### src/sed_front.sv
// front end: absolute coordinate differences, squares, sum and saturation check
// depends on sed_pkg
module sed_front
    import sed_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_kind,
    input  logic [6*COORD_W-1:0] i_coords,
    output t_root_lane         o_lane
);

    logic               r_v1, r_v2, r_v3;
    t_mag               r_mag [3];
    logic [SQ_W-1:0]    r_sq  [3];
    logic [SUM_W-1:0]   r_sum;
    t_root_lane         r_lane;
    t_mag               n_mag [3];

    always_comb begin
        logic signed [COORD_W:0] d;
        for (int i = 0; i < 3; i++) begin
            d = {i_coords[i*COORD_W + COORD_W-1], i_coords[i*COORD_W +: COORD_W]}
              - {i_coords[(i+3)*COORD_W + COORD_W-1], i_coords[(i+3)*COORD_W +: COORD_W]};
            n_mag[i] = d[COORD_W] ? MAG_W'(-d) : MAG_W'(d);
        end
        // planar items drop z
        if (!i_kind) begin
            n_mag[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_v1         <= i_valid;
            r_v2         <= r_v1;
            r_v3         <= r_v2;
            r_lane.valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= n_mag[i];
                r_sq[i]  <= SQ_W'(r_mag[i]) * SQ_W'(r_mag[i]);
            end
            r_sum       <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
            r_lane.sat  <= (r_sum > SAT_LIMIT);
            r_lane.rem  <= ROOT_W'(r_sum);
            r_lane.root <= '0;
        end
    end

    assign o_lane = r_lane;

endmodule

### src/sed_root_cell.sv
// one step of the bit-serial square root, registered
// depends on sed_pkg
module sed_root_cell
    import sed_pkg::*;
#(
    parameter int LEVEL = 0
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_root_lane i_lane,
    output t_root_lane o_lane
);

    localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * LEVEL);

    logic [ROOT_W-1:0] w_trial;
    t_root_lane        n_lane;
    t_root_lane        r_lane;

    assign w_trial = i_lane.root + BIT;

    always_comb begin
        n_lane = i_lane;
        if (w_trial <= i_lane.rem) begin
            n_lane.rem  = i_lane.rem - w_trial;
            n_lane.root = (w_trial + BIT) >> 1;
        end else begin
            n_lane.root = i_lane.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.valid <= 1'b0;
        end else if (i_en) begin
            r_lane.valid <= n_lane.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane.sat  <= n_lane.sat;
            r_lane.rem  <= n_lane.rem;
            r_lane.root <= n_lane.root;
        end
    end

    assign o_lane = r_lane;

endmodule
